### sv/srm_pkg.sv
// ----------------------------------------------------------------------------
// srm_pkg: shared types and constants for the section region map
// Holds field widths, opcode and status codes, and the stored region entry.
// ----------------------------------------------------------------------------
package srm_pkg;

    localparam int ADDR_W          = 32;
    localparam int ATTR_W          = 20;
    localparam int SECT_SHIFT      = 20;
    localparam int OP_W            = 2;
    localparam int STATUS_W        = 3;
    localparam int IDX_W           = 5;
    localparam int HELD_W          = 6;
    localparam int MAX_REGIONS_DEF = 32;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_LOOKUP = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_EMPTY_OR_FULL = 3'd1,
        ST_MISALIGNED    = 3'd2,
        ST_OUT_OF_RANGE  = 3'd3,
        ST_UNSORTED      = 3'd4,
        ST_OVERLAP       = 3'd5
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
        logic [ATTR_W-1:0] attr;
    } t_region;

endpackage

### sv/srm_if.sv
// ----------------------------------------------------------------------------
// srm_if: request and response channels of the section region map
// Valid/ready channels; a transaction moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface srm_in_if;
    logic                          valid;
    logic                          ready;
    logic [srm_pkg::OP_W-1:0]      op;
    logic [srm_pkg::ADDR_W-1:0]    region_base;
    logic [srm_pkg::ADDR_W-1:0]    region_size;
    logic [srm_pkg::ATTR_W-1:0]    region_attr;
    logic [srm_pkg::ADDR_W-1:0]    address;

    modport source (output valid, op, region_base, region_size, region_attr, address,
                    input ready);
    modport sink   (input valid, op, region_base, region_size, region_attr, address,
                    output ready);
endinterface

interface srm_out_if;
    logic                          valid;
    logic                          ready;
    logic [srm_pkg::STATUS_W-1:0]  status;
    logic                          hit;
    logic [srm_pkg::IDX_W-1:0]     region_index;
    logic [srm_pkg::ADDR_W-1:0]    descriptor;
    logic [srm_pkg::HELD_W-1:0]    regions_held;

    modport source (output valid, status, hit, region_index, descriptor, regions_held,
                    input ready);
    modport sink   (input valid, status, hit, region_index, descriptor, regions_held,
                    output ready);
endinterface

### sv/srm_region_ram.sv
// ----------------------------------------------------------------------------
// srm_region_ram: region entry memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module srm_region_ram #(
    parameter int DEPTH = srm_pkg::MAX_REGIONS_DEF,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  srm_pkg::t_region i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output srm_pkg::t_region o_rd_data
);
    import srm_pkg::*;

    t_region r_mem [DEPTH];
    t_region r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/section_region_map.sv
// ----------------------------------------------------------------------------
// section_region_map: table of identity-mapped 1 MB section regions
//
// i_req carries one command per transaction: clear, append a region, or look
// up an address. o_rsp returns exactly one transaction per command with the
// table status, the lookup hit, the first matching region index, the L1
// section descriptor (0 on a miss) and the number of stored regions.
// For clear, append and the unused opcode the response is registered at the
// accepting edge. A lookup walks the stored regions in order, one memory
// read per cycle, and stops at the first hit. The walk is bound by the
// single read port of the region memory.
// One command is in flight at a time; a new command is taken as soon as the
// previous response is taken or leaves the output register in that cycle.
// When o_rsp stalls, the response holds and i_req waits.
// Reset empties the table and clears all status; no memory sweep is needed.
// ----------------------------------------------------------------------------
module section_region_map #(
    parameter int MAX_REGIONS = srm_pkg::MAX_REGIONS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    srm_in_if.sink    i_req,
    srm_out_if.source o_rsp
);
    import srm_pkg::*;

    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int HW = $clog2(MAX_REGIONS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [HW-1:0]       r_held, n_held;
    logic                r_ovf, n_ovf;
    t_status             r_err, n_err;
    logic [ADDR_W-1:0]   r_last_base, n_last_base;
    logic [ADDR_W:0]     r_last_end, n_last_end;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [HW-1:0]       r_ptr, n_ptr;
    logic                r_rd_vld, n_rd_vld;
    logic [IW-1:0]       r_rd_idx, n_rd_idx;
    logic                r_hit, n_hit;
    logic [IW-1:0]       r_idx, n_idx;
    logic [ADDR_W-1:0]   r_desc, n_desc;

    logic                r_o_valid;
    t_status             r_o_status;
    logic                r_o_hit;
    logic [IDX_W-1:0]    r_o_idx;
    logic [ADDR_W-1:0]   r_o_desc;
    logic [HELD_W-1:0]   r_o_held;

    logic                out_free;
    logic                accept;
    logic                load_out;
    logic                res_hit;
    logic [IW-1:0]       res_idx;
    logic [ADDR_W-1:0]   res_desc;
    t_status             status_next;
    logic                issue;
    logic                match;
    logic                wr_en;
    logic [ADDR_W:0]     app_end;
    logic [ADDR_W:0]     rd_end;
    t_status             app_err;
    t_region             wr_entry;
    t_region             rd_entry;

    srm_region_ram #(
        .DEPTH (MAX_REGIONS),
        .AW    (IW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_held[IW-1:0]),
        .i_wr_data (wr_entry),
        .i_rd_addr (r_ptr[IW-1:0]),
        .o_rd_data (rd_entry)
    );

    assign out_free    = !r_o_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && out_free;
    assign accept      = i_req.valid && i_req.ready;

    assign wr_entry.base = i_req.region_base;
    assign wr_entry.size = i_req.region_size;
    assign wr_entry.attr = i_req.region_attr;
    assign wr_en = accept && (i_req.op == OP_APPEND) && (r_held < HW'(MAX_REGIONS));

    assign app_end = {1'b0, i_req.region_base} + {1'b0, i_req.region_size};

    always_comb begin
        app_err = ST_OK;
        if ((i_req.region_size == '0) || (i_req.region_base[SECT_SHIFT-1:0] != '0)
            || (i_req.region_size[SECT_SHIFT-1:0] != '0)) begin
            app_err = ST_MISALIGNED;
        end else if (app_end[ADDR_W] && (app_end[ADDR_W-1:0] != '0)) begin
            app_err = ST_OUT_OF_RANGE;
        end else if ((r_held != '0) && (i_req.region_base < r_last_base)) begin
            app_err = ST_UNSORTED;
        end else if ((r_held != '0) && ({1'b0, i_req.region_base} < r_last_end)) begin
            app_err = ST_OVERLAP;
        end
    end

    assign issue  = r_ptr < r_held;
    assign rd_end = {1'b0, rd_entry.base} + {1'b0, rd_entry.size};
    assign match  = (r_addr >= rd_entry.base) && ({1'b0, r_addr} < rd_end);

    always_comb begin
        n_state     = r_state;
        n_held      = r_held;
        n_ovf       = r_ovf;
        n_err       = r_err;
        n_last_base = r_last_base;
        n_last_end  = r_last_end;
        n_addr      = r_addr;
        n_ptr       = r_ptr;
        n_rd_vld    = r_rd_vld;
        n_rd_idx    = r_rd_idx;
        n_hit       = r_hit;
        n_idx       = r_idx;
        n_desc      = r_desc;
        load_out    = 1'b0;
        res_hit     = 1'b0;
        res_idx     = '0;
        res_desc    = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    load_out = (i_req.op != OP_LOOKUP);
                    case (i_req.op)
                        OP_CLEAR: begin
                            n_held      = '0;
                            n_ovf       = 1'b0;
                            n_err       = ST_OK;
                            n_last_base = '0;
                            n_last_end  = '0;
                        end
                        OP_APPEND: begin
                            if (r_held >= HW'(MAX_REGIONS)) begin
                                n_ovf = 1'b1;
                            end else begin
                                if (r_err == ST_OK) begin
                                    n_err = app_err;
                                end
                                n_held      = r_held + 1'b1;
                                n_last_base = i_req.region_base;
                                n_last_end  = app_end;
                            end
                        end
                        OP_LOOKUP: begin
                            n_addr   = i_req.address;
                            n_ptr    = '0;
                            n_rd_vld = 1'b0;
                            n_state  = S_LOOK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOOK: begin
                n_ptr    = issue ? r_ptr + 1'b1 : r_ptr;
                n_rd_vld = issue;
                n_rd_idx = r_ptr[IW-1:0];
                if (r_rd_vld && match) begin
                    n_hit   = 1'b1;
                    n_idx   = r_rd_idx;
                    n_desc  = {r_addr[ADDR_W-1:SECT_SHIFT], rd_entry.attr};
                    n_state = S_DONE;
                end else if (!issue) begin
                    n_hit   = 1'b0;
                    n_idx   = '0;
                    n_desc  = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    res_hit  = r_hit;
                    res_idx  = r_idx;
                    res_desc = r_desc;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign status_next = ((n_held == '0) || n_ovf) ? ST_EMPTY_OR_FULL : n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_ovf       <= 1'b0;
            r_err       <= ST_OK;
            r_last_base <= '0;
            r_last_end  <= '0;
            r_rd_vld    <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_ovf       <= n_ovf;
            r_err       <= n_err;
            r_last_base <= n_last_base;
            r_last_end  <= n_last_end;
            r_rd_vld    <= n_rd_vld;
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_ptr    <= n_ptr;
        r_rd_idx <= n_rd_idx;
        r_hit    <= n_hit;
        r_idx    <= n_idx;
        r_desc   <= n_desc;
        if (load_out) begin
            r_o_status <= status_next;
            r_o_hit    <= res_hit;
            r_o_idx    <= IDX_W'(res_idx);
            r_o_desc   <= res_desc;
            r_o_held   <= HELD_W'(n_held);
        end
    end

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.hit          = r_o_hit;
    assign o_rsp.region_index = r_o_idx;
    assign o_rsp.descriptor   = r_o_desc;
    assign o_rsp.regions_held = r_o_held;

endmodule

### sv/srm_checker.sv
// ----------------------------------------------------------------------------
// srm_checker: port-level checks for the section region map
// Watches both channels over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module srm_checker (
    input logic      i_clk,
    input logic      i_rst_n,
    srm_in_if.sink   i_req,
    srm_out_if.source o_rsp
);
    import srm_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.descriptor)
            && $stable(o_rsp.status))
        else $error("response changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.hit |-> (o_rsp.region_index == '0)
            && (o_rsp.descriptor == '0))
        else $error("miss carries nonzero index or descriptor");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.regions_held == '0) |-> (o_rsp.status == ST_EMPTY_OR_FULL))
        else $error("empty table without empty status");

    a_hit_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.hit |-> (o_rsp.regions_held != '0))
        else $error("hit reported on an empty table");

    a_req_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> (!o_rsp.valid || o_rsp.ready))
        else $error("request ready while response stalled");

endmodule

bind section_region_map srm_checker u_srm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_req   (i_req),
    .o_rsp   (o_rsp)
);
